// ===== hdl/framed_crc16_frame_checker_defines.svh =====
// Assertion macros used by the frame checker core.
`ifndef FRAMED_CRC16_FRAME_CHECKER_DEFINES_SVH
`define FRAMED_CRC16_FRAME_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FCRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define FCRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FCRC_ASSERT(lbl, clk, rst, prop, msg)

`define FCRC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/fcrc_pkg.sv =====
// Types, constants and the byte-wide CRC-16 update of the frame checker.
package fcrc_pkg;

  localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int          BITS_PER_BYTE = 8;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } fcrc_item_t;

  function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                  input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/fcrc_byte_if.sv =====
// Handshake channel that carries one received byte per word.
interface fcrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/fcrc_result_if.sv =====
// Handshake channel that carries one frame check result per word.
interface fcrc_result_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [15:0] computed_crc;

  modport source (output valid, output crc_ok, output computed_crc, input ready);
  modport sink (input valid, input crc_ok, input computed_crc, output ready);
endinterface

// ===== hdl/fcrc_in_stage.sv =====
// Input register that holds one received byte until the checker core takes it.
module fcrc_in_stage (
  input  logic               clk,
  input  logic               rst,
  fcrc_byte_if.sink          rx,
  input  logic               core_ready,
  output fcrc_pkg::fcrc_item_t item
);

  logic       valid;
  logic [7:0] rx_byte;

  assign rx.ready     = !valid || core_ready;
  assign item.valid   = valid;
  assign item.rx_byte = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      valid <= 1'b1;
    end else if (core_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      rx_byte <= rx.rx_byte;
    end
  end

endmodule

// ===== hdl/fcrc_core.sv =====
// Frame position counter, running CRC and result register of the frame checker.
`include "framed_crc16_frame_checker_defines.svh"

module fcrc_core #(
  parameter int FRAME_LEN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fcrc_pkg::fcrc_item_t item,
  output logic                 core_ready,
  fcrc_result_if.source        result
);

  localparam int            CW        = $clog2(FRAME_LEN);
  localparam logic [CW-1:0] LAST_DATA = CW'(FRAME_LEN - 2);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [15:0]   running_crc;
  logic [15:0]   running_crc_next;
  logic [7:0]    received_crc_low;
  logic [7:0]    received_crc_low_next;
  logic          res_valid;
  logic          crc_ok;
  logic [15:0]   computed_crc;
  logic          take;
  logic          is_flag;
  logic          load;

  assign core_ready = !res_valid || result.ready;
  assign take       = item.valid && core_ready;
  assign is_flag    = (item.rx_byte == fcrc_pkg::FLAG_BYTE);

  assign result.valid        = res_valid;
  assign result.crc_ok       = crc_ok;
  assign result.computed_crc = computed_crc;

  always_comb begin
    count_next            = count;
    running_crc_next      = running_crc;
    received_crc_low_next = received_crc_low;
    load                  = 1'b0;
    if (take) begin
      if (is_flag) begin
        count_next       = '0;
        running_crc_next = fcrc_pkg::CRC_INIT;
      end else if (count < LAST_DATA) begin
        running_crc_next = fcrc_pkg::crc_byte_update(running_crc, item.rx_byte);
        count_next       = count + CW'(1);
      end else if (count == LAST_DATA) begin
        received_crc_low_next = item.rx_byte;
        count_next            = count + CW'(1);
      end else begin
        load             = 1'b1;
        count_next       = '0;
        running_crc_next = fcrc_pkg::CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_crc <= fcrc_pkg::CRC_INIT;
      res_valid   <= 1'b0;
    end else begin
      count       <= count_next;
      running_crc <= running_crc_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    received_crc_low <= received_crc_low_next;
    if (load) begin
      crc_ok       <= (received_crc_low == running_crc[7:0]) &&
                      (item.rx_byte == running_crc[15:8]);
      computed_crc <= running_crc;
    end
  end

  `FCRC_ASSERT(a_flag_restarts, clk, rst, take && is_flag |=> count == '0 && running_crc == fcrc_pkg::CRC_INIT, "flag byte did not restart the frame")
  `FCRC_ASSERT(a_count_steps, clk, rst, take && !is_flag && count <= LAST_DATA |=> count == $past(count) + CW'(1), "data byte did not advance the count")
  `FCRC_ASSERT(a_final_emits, clk, rst, take && !is_flag && count > LAST_DATA |=> res_valid && count == '0, "final byte did not produce a result")

endmodule

// ===== hdl/framed_crc16_frame_checker.sv =====
// A byte accepted from rx waits in the input register until the core takes it; a data
// byte updates the running CRC, and the final byte of a frame loads the result register.
// Throughput: one byte per cycle while the result channel is not stalled.
// Synchronous reset empties both registers, clears the frame position and loads
// the CRC with 0xFFFF.
// Top level of the framed Modbus CRC-16 frame checker.
module framed_crc16_frame_checker #(
  parameter int FRAME_LEN = 8
) (
  input  logic          clk,
  input  logic          rst,
  fcrc_byte_if.sink     rx,
  fcrc_result_if.source result
);

  fcrc_pkg::fcrc_item_t item;
  logic                 core_ready;

  fcrc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .core_ready (core_ready),
    .item       (item)
  );

  fcrc_core #(
    .FRAME_LEN (FRAME_LEN)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .core_ready (core_ready),
    .result     (result)
  );

endmodule
